// File: rtl/raa_pkg.sv
// raa_pkg: shared constants, codes and controller/datapath link types
// for the region adjacency accumulator; no dependencies
package raa_pkg;

    localparam int LABEL_W        = 12;
    localparam int TOTAL_W        = 32;
    localparam int LABELS_DEF     = 4096;
    localparam int MAX_NB_DEF     = 16;
    localparam int COUNT_BITS_DEF = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LABEL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_CONNECTED = 1'd1;

    // request function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_WINDOW = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic load_wr;
        logic cap_hdr;
        logic fetch_cap;
        logic scan;
        logic commit;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_valid;
        logic clr_done;
        logic drop;
        logic is_load;
        logic fetch_done;
        logic scan_done;
        logic cnt_one;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

// File: rtl/raa_in_if.sv
// raa_in_if: input request channel (valid/ready plus window payload)
// depends on raa_pkg
interface raa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [raa_pkg::LABEL_W-1:0]   center_label;
    logic [raa_pkg::TOTAL_W-1:0]   pixel_total;
    logic [raa_pkg::LABEL_W-1:0]   up_left;
    logic [raa_pkg::LABEL_W-1:0]   left;
    logic [raa_pkg::LABEL_W-1:0]   down_left;
    logic [raa_pkg::LABEL_W-1:0]   up;
    logic [raa_pkg::LABEL_W-1:0]   down;
    logic [raa_pkg::LABEL_W-1:0]   up_right;
    logic [raa_pkg::LABEL_W-1:0]   right;
    logic [raa_pkg::LABEL_W-1:0]   down_right;

    modport source (output valid, func, center_label, pixel_total, up_left, left,
                    down_left, up, down, up_right, right, down_right, input ready);
    modport sink (input valid, func, center_label, pixel_total, up_left, left,
                  down_left, up, down, up_right, right, down_right, output ready);
endinterface

// File: rtl/raa_out_if.sv
// raa_out_if: result channel (valid/ready plus neighbour list entry)
// depends on raa_pkg
interface raa_out_if;
    logic                          valid;
    logic                          ready;
    logic [raa_pkg::LABEL_W-1:0]   region_label;
    logic [raa_pkg::LABEL_W-1:0]   neighbour_label;
    logic                          has_neighbour;
    logic                          list_overflow;
    logic                          last;

    modport source (output valid, region_label, neighbour_label, has_neighbour,
                    list_overflow, last, input ready);
    modport sink (input valid, region_label, neighbour_label, has_neighbour,
                  list_overflow, last, output ready);
endinterface

// File: rtl/region_adjacency_accumulator_unit.sv
// Region adjacency accumulator. After reset a clearing pass over all LABELS
// entries (4096 by default) zeroes the list lengths; no request is taken
// until it ends. Configuration writes belong where no request is in flight.
// A window request fetches the centre's current list from the neighbour
// memory one entry at a time (registered read), then runs eight neighbour
// checks one per cycle against the cached list. When the count reaches zero
// the list is sent out from the result register, one result per cycle while
// the receiver keeps up. Requests with a centre at or beyond LABELS, or equal
// to the ignore label on a window, are dropped.
// depends on raa_pkg, raa_in_if, raa_out_if, raa_ctrl, raa_dp
module region_adjacency_accumulator_unit #(
    parameter int LABELS     = raa_pkg::LABELS_DEF,
    parameter int MAX_NB     = raa_pkg::MAX_NB_DEF,
    parameter int COUNT_BITS = raa_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [raa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [raa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    raa_in_if.sink                         i_in,
    raa_out_if.source                      o_out
);
    raa_pkg::t_cmd w_cmd;
    raa_pkg::t_sts w_sts;

    // sequencing
    raa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    // storage and result path
    raa_dp #(
        .LABELS    (LABELS),
        .MAX_NB    (MAX_NB),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_in      (i_in),
        .o_out     (o_out)
    );
endmodule

// File: rtl/raa_ram.sv
// raa_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module raa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/raa_ctrl.sv
// raa_ctrl: sequencing state machine for the adjacency accumulator
// depends on raa_pkg
module raa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  raa_pkg::t_sts i_sts,
    output raa_pkg::t_cmd o_cmd
);
    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DECODE  = 4'd2;
    localparam logic [3:0] ST_HDR     = 4'd3;
    localparam logic [3:0] ST_FETCH_A = 4'd4;
    localparam logic [3:0] ST_FETCH_D = 4'd5;
    localparam logic [3:0] ST_SCAN    = 4'd6;
    localparam logic [3:0] ST_COMMIT  = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = !i_sts.clr_done;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (i_sts.drop) begin
                    n_state = ST_IDLE;
                end else if (i_sts.is_load) begin
                    o_cmd.load_wr = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    n_state = ST_HDR;
                end
            end
            ST_HDR: begin
                o_cmd.cap_hdr = 1'b1;
                n_state       = ST_FETCH_A;
            end
            ST_FETCH_A: begin
                n_state = i_sts.fetch_done ? ST_SCAN : ST_FETCH_D;
            end
            ST_FETCH_D: begin
                o_cmd.fetch_cap = 1'b1;
                n_state         = ST_FETCH_A;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = i_sts.cnt_one ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_state != ST_CLEAR))
        else $error("clearing pass restarted");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("emit while result register busy");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.in_ready |-> (!o_cmd.scan && !o_cmd.emit && !o_cmd.commit))
        else $error("request taken during item work");
`endif
endmodule

// File: rtl/raa_dp.sv
// raa_dp: datapath with count, length and neighbour memories, list cache
// and result register; depends on raa_pkg, raa_ram, raa_in_if, raa_out_if
module raa_dp #(
    parameter int LABELS     = raa_pkg::LABELS_DEF,
    parameter int MAX_NB     = raa_pkg::MAX_NB_DEF,
    parameter int COUNT_BITS = raa_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [raa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [raa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  raa_pkg::t_cmd                     i_cmd,
    output raa_pkg::t_sts                     o_sts,
    raa_in_if.sink                            i_in,
    raa_out_if.source                         o_out
);
    localparam int LW     = raa_pkg::LABEL_W;
    localparam int LBL_AW = $clog2(LABELS);
    localparam int LEN_W  = $clog2(MAX_NB + 1);
    localparam int SLOT_W = (MAX_NB > 1) ? $clog2(MAX_NB) : 1;
    localparam int NB_D   = LABELS * MAX_NB;
    localparam int NB_AW  = $clog2(NB_D);
    localparam int EXT_W  = 17;

    // configuration registers
    logic [LW-1:0] r_ign;
    logic          r_four;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign  <= '0;
            r_four <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                raa_pkg::CFG_IGNORE_LABEL:   r_ign  <= i_cfg_data[LW-1:0];
                raa_pkg::CFG_FOUR_CONNECTED: r_four <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // latched request
    logic                          r_func;
    logic [LW-1:0]                 r_ctr;
    logic [raa_pkg::TOTAL_W-1:0]   r_total;
    logic [LW-1:0]                 r_nb [8];

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ready && i_in.valid) begin
            r_func  <= i_in.func;
            r_ctr   <= i_in.center_label;
            r_total <= i_in.pixel_total;
            r_nb[0] <= i_in.up_left;
            r_nb[1] <= i_in.left;
            r_nb[2] <= i_in.down_left;
            r_nb[3] <= i_in.up;
            r_nb[4] <= i_in.down;
            r_nb[5] <= i_in.up_right;
            r_nb[6] <= i_in.right;
            r_nb[7] <= i_in.down_right;
        end
    end

    assign i_in.ready = i_cmd.in_ready;

    logic [EXT_W-1:0]  w_ctr_ext;
    logic [LBL_AW-1:0] w_cidx;
    logic [NB_AW-1:0]  w_base;
    assign w_ctr_ext = EXT_W'(r_ctr);
    assign w_cidx    = w_ctr_ext[LBL_AW-1:0];
    assign w_base    = NB_AW'(w_cidx) * NB_AW'(MAX_NB);

    // working registers
    logic [COUNT_BITS-1:0] r_cnt;
    logic [LEN_W-1:0]      r_len;
    logic                  r_ovf;
    logic [LEN_W-1:0]      r_j;
    logic [2:0]            r_k;
    logic [LW-1:0]         r_list [MAX_NB];
    logic [LBL_AW:0]       r_clr;

    // memories
    logic [COUNT_BITS-1:0] w_cnt_rd;
    logic [LEN_W:0]        w_len_rd;
    logic [LW-1:0]         w_nb_rd;
    logic                  w_cnt_we;
    logic [COUNT_BITS-1:0] w_cnt_wd;
    logic                  w_len_we;
    logic [LBL_AW-1:0]     w_len_wa;
    logic [LEN_W:0]        w_len_wd;
    logic                  w_nb_we;

    // neighbour check for the current scan step
    logic [LW-1:0] w_n;
    logic          w_diag;
    logic          w_hit;
    logic          w_add;
    logic          w_full;

    always_comb begin
        w_n    = r_nb[r_k];
        w_diag = r_k inside {3'd0, 3'd2, 3'd5, 3'd7};
        w_hit  = 1'b0;
        for (int i = 0; i < MAX_NB; i++) begin
            if ((LEN_W'(i) < r_len) && (r_list[i] == w_n)) w_hit = 1'b1;
        end
        w_add  = !(r_four && w_diag) && (w_n != r_ctr) && (w_n != r_ign) && !w_hit;
        w_full = (r_len == LEN_W'(MAX_NB));
    end

    assign w_cnt_we = i_cmd.load_wr || i_cmd.commit;
    assign w_cnt_wd = i_cmd.load_wr ? COUNT_BITS'(r_total) : (r_cnt - COUNT_BITS'(1));
    assign w_len_we = i_cmd.clr_wr || i_cmd.commit;
    assign w_len_wa = i_cmd.clr_wr ? r_clr[LBL_AW-1:0] : w_cidx;
    assign w_len_wd = (i_cmd.clr_wr || o_sts.cnt_one) ? '0 : {r_ovf, r_len};
    assign w_nb_we  = i_cmd.scan && w_add && !w_full;

    raa_ram #(.WIDTH(COUNT_BITS), .DEPTH(LABELS)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (w_cnt_we),
        .i_waddr(w_cidx),
        .i_wdata(w_cnt_wd),
        .i_raddr(w_cidx),
        .o_rdata(w_cnt_rd)
    );

    raa_ram #(.WIDTH(LEN_W + 1), .DEPTH(LABELS)) u_len_ram (
        .i_clk  (i_clk),
        .i_we   (w_len_we),
        .i_waddr(w_len_wa),
        .i_wdata(w_len_wd),
        .i_raddr(w_cidx),
        .o_rdata(w_len_rd)
    );

    raa_ram #(.WIDTH(LW), .DEPTH(NB_D)) u_nb_ram (
        .i_clk  (i_clk),
        .i_we   (w_nb_we),
        .i_waddr(w_base + NB_AW'(r_len)),
        .i_wdata(w_n),
        .i_raddr(w_base + NB_AW'(r_j)),
        .o_rdata(w_nb_rd)
    );

    // clearing pass, header capture, list fetch, scan and emission counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
        if (i_cmd.cap_hdr) begin
            r_cnt <= w_cnt_rd;
            r_len <= w_len_rd[LEN_W-1:0];
            r_ovf <= w_len_rd[LEN_W];
            r_j   <= '0;
            r_k   <= '0;
        end
        if (i_cmd.fetch_cap) begin
            r_list[r_j[SLOT_W-1:0]] <= w_nb_rd;
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.scan) begin
            r_k <= r_k + 1'b1;
            if (w_add && !w_full) begin
                r_list[r_len[SLOT_W-1:0]] <= w_n;
                r_len <= r_len + 1'b1;
            end else if (w_add) begin
                r_ovf <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_j <= '0;
        end
        if (i_cmd.emit) begin
            r_j <= r_j + 1'b1;
        end
    end

    // result register
    logic          r_ovalid;
    logic [LW-1:0] r_o_region;
    logic [LW-1:0] r_o_nb;
    logic          r_o_has;
    logic          r_o_ovf;
    logic          r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_o_region <= r_ctr;
            r_o_nb     <= (r_len != '0) ? r_list[r_j[SLOT_W-1:0]] : '0;
            r_o_has    <= (r_len != '0);
            r_o_ovf    <= r_ovf;
            r_o_last   <= o_sts.emit_last;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.region_label    = r_o_region;
    assign o_out.neighbour_label = r_o_nb;
    assign o_out.has_neighbour   = r_o_has;
    assign o_out.list_overflow   = r_o_ovf;
    assign o_out.last            = r_o_last;

    // status
    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.clr_done   = (r_clr == (LBL_AW + 1)'(LABELS));
    assign o_sts.drop       = (w_ctr_ext >= EXT_W'(LABELS))
                              || ((r_func == raa_pkg::FUNC_WINDOW) && (r_ctr == r_ign));
    assign o_sts.is_load    = (r_func == raa_pkg::FUNC_LOAD);
    assign o_sts.fetch_done = (r_j == r_len);
    assign o_sts.scan_done  = (r_k == 3'd7);
    assign o_sts.cnt_one    = (r_cnt == COUNT_BITS'(1));
    assign o_sts.out_free   = !r_ovalid || o_out.ready;
    assign o_sts.emit_last  = (r_len == '0) || ((r_j + 1'b1) == r_len);

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_len <= LEN_W'(MAX_NB)))
        else $error("list length beyond capacity");
    a_fetch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch_cap |-> (r_j < r_len))
        else $error("list fetch past length");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (r_len != '0)) |-> (r_j < r_len))
        else $error("emission past list length");
`endif
endmodule

// File: verif/tb_region_adjacency_accumulator_unit.sv
`timescale 1ns / 100ps
// tb_region_adjacency_accumulator_unit: self-checking bench for the region adjacency
// accumulator; keeps its own neighbour-list predictor and checks every list entry
// depends on raa_pkg, raa_in_if, raa_out_if, region_adjacency_accumulator_unit
module tb_region_adjacency_accumulator_unit;

    localparam int MAX_NB      = 16;
    localparam int SETTLE      = 80;
    localparam int CYCLE_LIMIT = 600000;

    typedef logic [raa_pkg::LABEL_W-1:0] t_label;

    typedef struct {
        logic   func;
        t_label center;
        logic [raa_pkg::TOTAL_W-1:0] total;
        t_label nb [8];   // up_left, left, down_left, up, down, up_right, right, down_right
    } t_req;

    typedef struct packed {
        t_label region;
        t_label neighbour;
        logic   has_nb;
        logic   ovf;
        logic   last;
    } t_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [raa_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [raa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    raa_in_if  in_ch();
    raa_out_if out_ch();

    region_adjacency_accumulator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [31:0] pixels_left [4096];
    t_label      nb_store [4096][MAX_NB];
    int          nb_len [4096];
    bit          nb_ovf [4096];
    t_label      ignore_reg = '0;
    logic        four_reg = 1'b1;
    t_entry      pending_entries [$];

    int  mismatches = 0;
    int  entries_seen = 0;
    int  windows_sent = 0;
    int  loads_sent = 0;
    int  overflow_lists = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    initial begin
        for (int i = 0; i < 4096; i++) begin
            nb_len[i] = 0;
            nb_ovf[i] = 0;
        end
        in_ch.valid = 1'b0;
        in_ch.func = raa_pkg::FUNC_LOAD;
        in_ch.center_label = '0;
        in_ch.pixel_total = '0;
        in_ch.up_left = '0;
        in_ch.left = '0;
        in_ch.down_left = '0;
        in_ch.up = '0;
        in_ch.down = '0;
        in_ch.up_right = '0;
        in_ch.right = '0;
        in_ch.down_right = '0;
        out_ch.ready = 1'b0;
    end

    // append one neighbour to a region's list
    function automatic void add_neighbour(t_label c, t_label other);
        if (other == c || other == ignore_reg) return;
        for (int i = 0; i < nb_len[c]; i++)
            if (nb_store[c][i] == other) return;
        if (nb_len[c] < MAX_NB) begin
            nb_store[c][nb_len[c]] = other;
            nb_len[c]++;
        end else begin
            nb_ovf[c] = 1'b1;
        end
    endfunction

    // update lists and counts for one accepted request, queue emitted entries
    function automatic void predict_adjacency(t_req r);
        t_label c;
        bit diag;
        t_entry e;
        c = r.center;
        if (r.func == raa_pkg::FUNC_LOAD) begin
            pixels_left[c] = r.total;
            return;
        end
        if (c == ignore_reg) return;
        for (int k = 0; k < 8; k++) begin
            diag = k inside {0, 2, 5, 7};
            if (!(four_reg && diag)) add_neighbour(c, r.nb[k]);
        end
        pixels_left[c] = pixels_left[c] - 1;
        if (pixels_left[c] != 0) return;
        if (nb_ovf[c]) overflow_lists++;
        if (nb_len[c] == 0) begin
            e = '{region: c, neighbour: '0, has_nb: 1'b0, ovf: nb_ovf[c], last: 1'b1};
            pending_entries.insert(pending_entries.size(), e);
        end else begin
            for (int k = 0; k < nb_len[c]; k++) begin
                e = '{region: c, neighbour: nb_store[c][k], has_nb: 1'b1, ovf: nb_ovf[c],
                      last: (k + 1 == nb_len[c])};
                pending_entries.insert(pending_entries.size(), e);
            end
        end
        nb_len[c] = 0;
        nb_ovf[c] = 1'b0;
    endfunction

    // result receiver with random stalls
    always @(negedge i_clk)
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

    // result checker
    always @(posedge i_clk) begin
        t_entry got, exp_e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{region: out_ch.region_label, neighbour: out_ch.neighbour_label,
                    has_nb: out_ch.has_neighbour, ovf: out_ch.list_overflow,
                    last: out_ch.last};
            entries_seen++;
            if (pending_entries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: region %0d neighbour %0d",
                             got.region, got.neighbour);
            end else begin
                exp_e = pending_entries.pop_front();
                if (got !== exp_e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp region %0d nb %0d has %b ovf %b last %b,",
                                  " got region %0d nb %0d has %b ovf %b last %b"},
                                 exp_e.region, exp_e.neighbour, exp_e.has_nb, exp_e.ovf,
                                 exp_e.last, got.region, got.neighbour, got.has_nb,
                                 got.ovf, got.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_entries.size());
            $display("tb_region_adjacency_accumulator_unit: FAIL");
            $finish;
        end
    end

    // send one request, sometimes with a random gap before it
    task automatic send_request(t_req r);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 30) begin
            gap = $urandom_range(4, 1);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.func = r.func;
        in_ch.center_label = r.center;
        in_ch.pixel_total = r.total;
        in_ch.up_left = r.nb[0];
        in_ch.left = r.nb[1];
        in_ch.down_left = r.nb[2];
        in_ch.up = r.nb[3];
        in_ch.down = r.nb[4];
        in_ch.up_right = r.nb[5];
        in_ch.right = r.nb[6];
        in_ch.down_right = r.nb[7];
        in_ch.valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready) break;
        end
        if (r.func == raa_pkg::FUNC_LOAD) loads_sent++;
        else windows_sent++;
        predict_adjacency(r);
    endtask

    task automatic load_count(t_label c, logic [31:0] total);
        t_req r;
        r.func = raa_pkg::FUNC_LOAD;
        r.center = c;
        r.total = total;
        for (int k = 0; k < 8; k++) r.nb[k] = t_label'($urandom);
        send_request(r);
    endtask

    task automatic send_window(t_label c, t_label ul, t_label l, t_label dl, t_label u,
                               t_label d, t_label ur, t_label rt, t_label dr);
        t_req r;
        r.func = raa_pkg::FUNC_WINDOW;
        r.center = c;
        r.total = $urandom;
        r.nb = '{ul, l, dl, u, d, ur, rt, dr};
        send_request(r);
    endtask

    // wait for the block to go idle, then write one register
    task automatic write_register(logic [raa_pkg::CFG_IDX_W-1:0] idx,
                                  logic [raa_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == raa_pkg::CFG_IGNORE_LABEL) ignore_reg = val[raa_pkg::LABEL_W-1:0];
        else if (idx == raa_pkg::CFG_FOUR_CONNECTED) four_reg = val[0];
    endtask

    // four-connected basics, ignored centre, empty list, zero count and reload
    task automatic test_basic_lists();
        load_count(12'd1, 32'd2);
        send_window(12'd1, 12'd50, 12'd2, 12'd51, 12'd3, 12'd1, 12'd52, 12'd0, 12'd53);
        send_window(12'd1, 12'd54, 12'd3, 12'd55, 12'd4, 12'd4095, 12'd56, 12'd2, 12'd57);
        // centre equal to the ignore label
        send_window(12'd0, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9);
        // largest count, then reload; list stays empty
        load_count(12'd4095, 32'hFFFF_FFFF);
        load_count(12'd4095, 32'd1);
        send_window(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0);
        // zero count wraps; reload keeps the list
        load_count(12'd7, 32'd0);
        send_window(12'd7, 12'd0, 12'd8, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        load_count(12'd7, 32'd1);
        send_window(12'd7, 12'd0, 12'd8, 12'd0, 12'd9, 12'd0, 12'd0, 12'd0, 12'd0);
    endtask

    // eight-connected with the top label ignored, list filled past capacity
    task automatic test_overflow();
        write_register(raa_pkg::CFG_FOUR_CONNECTED, 12'd0);
        write_register(raa_pkg::CFG_IGNORE_LABEL, 12'hFFF);
        load_count(12'd10, 32'd3);
        send_window(12'd10, 12'd20, 12'd21, 12'd22, 12'd23, 12'd24, 12'd25, 12'd26, 12'd27);
        send_window(12'd10, 12'd30, 12'd31, 12'd32, 12'd33, 12'd34, 12'd35, 12'hFFF, 12'd10);
        send_window(12'd10, 12'd40, 12'd41, 12'd42, 12'd43, 12'd20, 12'd44, 12'd45, 12'd46);
    endtask

    // random phases over several register settings
    task automatic test_random_phase(logic [raa_pkg::CFG_DATA_W-1:0] ign, logic four,
                                     int n_items);
        t_label pool [4];
        t_label c;
        t_label nbv [8];
        int sent;
        write_register(raa_pkg::CFG_IGNORE_LABEL, ign);
        write_register(raa_pkg::CFG_FOUR_CONNECTED, {11'd0, four});
        for (int i = 0; i < 4; i++) begin
            do pool[i] = t_label'($urandom); while (pool[i] == ign);
            load_count(pool[i], $urandom_range(4, 1));
        end
        sent = 4;
        while (sent < n_items) begin
            if ($urandom_range(99) < 6) begin
                // noise: odd load, sometimes with a full-width count
                c = pool[$urandom_range(3)];
                load_count(c, ($urandom_range(1) != 0) ? 32'($urandom) : $urandom_range(5, 1));
            end else begin
                if ($urandom_range(99) < 8) c = ign;
                else c = pool[$urandom_range(3)];
                for (int k = 0; k < 8; k++) begin
                    case ($urandom_range(9))
                        0, 1, 2: nbv[k] = pool[$urandom_range(3)];
                        3:       nbv[k] = c;
                        4:       nbv[k] = ign;
                        default: nbv[k] = t_label'($urandom);
                    endcase
                end
                send_window(c, nbv[0], nbv[1], nbv[2], nbv[3], nbv[4], nbv[5], nbv[6],
                            nbv[7]);
            end
            sent++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_lists();
        test_overflow();
        test_random_phase(12'd0, 1'b1, 44);
        test_random_phase(12'hFFF, 1'b0, 44);
        calm = 1'b1;
        test_random_phase(12'($urandom), 1'b0, 44);
        calm = 1'b0;
        test_random_phase(12'($urandom), 1'b1, 44);
        test_random_phase(12'($urandom), 1'($urandom), 44);

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d load and %0d window requests, %0d list entries checked",
                 loads_sent, windows_sent, entries_seen);
        $display("%0d emitted lists had overflowed, %0d mismatches", overflow_lists,
                 mismatches);
        if (mismatches == 0 && pending_entries.size() == 0)
            $display("tb_region_adjacency_accumulator_unit: PASS");
        else
            $display("tb_region_adjacency_accumulator_unit: FAIL");
        $finish;
    end
endmodule

// File: files.f
rtl/raa_pkg.sv
rtl/raa_in_if.sv
rtl/raa_out_if.sv
rtl/raa_ram.sv
rtl/raa_ctrl.sv
rtl/raa_dp.sv
rtl/region_adjacency_accumulator_unit.sv
verif/tb_region_adjacency_accumulator_unit.sv
